@@ src/keyed_peer_slot_table_top_macros.svh @@
// assertion helpers used by the checker of this block
`ifndef KEYED_PEER_SLOT_TABLE_TOP_MACROS_SVH
`define KEYED_PEER_SLOT_TABLE_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define KPST_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kpst check failed");

// consequent checked in the cycle after the antecedent
`define KPST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kpst check failed");

`endif

@@ src/kpst_pkg.sv @@
package kpst_pkg;

   // operation selector carried in req_tuser
   typedef enum logic [2:0] {
      FN_SAVE     = 3'd0,
      FN_UPDATE   = 3'd1,
      FN_ERASE    = 3'd2,
      FN_ERASE_ALL = 3'd3,
      FN_READ_NTH = 3'd4,
      FN_COUNT    = 3'd5,
      FN_RESTORE  = 3'd6,
      FN_RSVD     = 3'd7
   } func_type;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOSPACE  = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;

   localparam int ADDR_W  = 48;
   localparam int KEY_W   = 64;
   localparam int CHAN_W  = 8;
   localparam int NTH_W   = 8;
   localparam int FUNC_W  = 3;
   localparam int TOTAL_W = 4;
   localparam int TOTAL_MAX = 15;

   // at most this many items in one restore run
   localparam int MAX_RUN = 8;
   localparam int RUN_W   = $clog2(MAX_RUN);

   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 192;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [KEY_W-1:0]  key_low;
      logic [KEY_W-1:0]  key_high;
      logic [ADDR_W-1:0] addr;
   } slot_entry_type;

   // result item, status in the lowest bits
   typedef struct packed {
      logic [TOTAL_W-1:0] used_total;
      logic [CHAN_W-1:0]  out_chan;
      logic [KEY_W-1:0]   out_key_low;
      logic [KEY_W-1:0]   out_key_high;
      logic [ADDR_W-1:0]  out_addr;
      logic [1:0]         status;
   } rsp_item_type;

   localparam int RSP_ITEM_W = $bits(rsp_item_type);

endpackage

@@ src/keyed_peer_slot_table_top.sv @@
// sequence: an item is taken in S_IDLE; each slot walked is looked at in S_RD, a slot to
// be read is read there and checked in S_CHK, and a walk with no early result closes in S_FIN
// throughput: one item at a time, as a new item is taken only in S_IDLE;
// a restore run reads each result from the slot memory and waits for a free output register
// reset: synchronous, clears the used marks and the used count; slot contents are
// not cleared, a slot is only read once it is marked used
module keyed_peer_slot_table_top #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // peer_addr, key_high, key_low, chan, nth
   input  logic [kpst_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func
   input  logic [kpst_pkg::FUNC_W-1:0]      req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, out_addr, out_key_high, out_key_low, out_chan, used_total, zero pad
   output logic [kpst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import kpst_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

   // one-hot sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,   // waiting for an item
      S_RD   = 4'b0010,   // look at the used mark, read the slot if needed
      S_CHK  = 4'b0100,   // slot data back from memory
      S_FIN  = 4'b1000    // walk over, close the operation
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      seen_ff, seen_in;     // used slots passed, for read nth
   logic [RUN_W-1:0]      run_ff, run_in;       // items sent in this restore run
   logic                  free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // latched request
   func_type              func_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [KEY_W-1:0]      khi_ff;
   logic [KEY_W-1:0]      klo_ff;
   logic [CHAN_W-1:0]     chan_ff;
   logic [NTH_W-1:0]      nth_ff;

   // slot memory, one write and one registered read a cycle
   slot_entry_type        slot_mem_ff [SLOT_COUNT];
   slot_entry_type        rd_data_ff;
   logic                  mem_re;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   slot_entry_type        mem_wdata;

   // output register
   logic                  rsp_vld_ff, rsp_vld_in;
   rsp_item_type          rsp_item_ff;
   logic                  rsp_last_ff;
   logic                  load;
   rsp_item_type          load_item;
   logic                  load_last;
   logic [TOTAL_W-1:0]    total_sat;
   logic                  out_free;
   logic                  more_used;
   logic                  req_take;
   logic                  addr_hit;
   logic                  run_last;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign addr_hit   = (rd_data_ff.addr == addr_ff);

   // any used slot above the current one
   always_comb begin
      more_used = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (i > int'(idx_ff)) begin
            more_used = more_used | used_ff[i];
         end
      end
   end

   assign run_last = !more_used || (run_ff == RUN_W'(MAX_RUN - 1));

   // used count after this cycle's update, saturated for the result
   assign total_sat = (int'(cnt_in) > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(cnt_in);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      seen_in     = seen_ff;
      run_in      = run_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      used_in     = used_ff;
      cnt_in      = cnt_ff;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = idx_ff;
      mem_wdata   = '{chan: chan_ff, key_low: klo_ff, key_high: khi_ff, addr: addr_ff};
      load        = 1'b0;
      load_item   = '0;
      load_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               idx_in      = '0;
               seen_in     = '0;
               run_in      = '0;
               free_vld_in = 1'b0;
               case (func_type'(req_tuser))
                  FN_SAVE, FN_UPDATE, FN_ERASE, FN_READ_NTH, FN_RESTORE: begin
                     state_in = S_RD;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         S_RD: begin
            if (used_ff[idx_ff] &&
                (func_ff != FN_READ_NTH || NTH_W'(seen_ff) == nth_ff)) begin
               mem_re   = 1'b1;
               state_in = S_CHK;
            end else begin
               if (used_ff[idx_ff]) begin
                  seen_in = seen_ff + 1'b1;
               end
               if (!used_ff[idx_ff] && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (idx_ff == IDX_LAST) begin
                  state_in = S_FIN;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_CHK: begin
            case (func_ff)
               FN_SAVE, FN_UPDATE, FN_ERASE: begin
                  if (addr_hit) begin
                     if (out_free) begin
                        load      = 1'b1;
                        load_item.status = STAT_OK;
                        state_in  = S_IDLE;
                        if (func_ff == FN_SAVE) begin
                           mem_we = 1'b1;
                        end else if (func_ff == FN_UPDATE) begin
                           // channel changes, the rest is written back as read
                           mem_we    = 1'b1;
                           mem_wdata = '{chan: chan_ff, key_low: rd_data_ff.key_low,
                                         key_high: rd_data_ff.key_high,
                                         addr: rd_data_ff.addr};
                           load_item.out_addr     = rd_data_ff.addr;
                           load_item.out_key_high = rd_data_ff.key_high;
                           load_item.out_key_low  = rd_data_ff.key_low;
                           load_item.out_chan     = chan_ff;
                        end else begin
                           used_in[idx_ff] = 1'b0;
                           cnt_in          = cnt_ff - 1'b1;
                        end
                     end
                  end else if (idx_ff == IDX_LAST) begin
                     state_in = S_FIN;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               FN_READ_NTH: begin
                  if (out_free) begin
                     load               = 1'b1;
                     load_item.status   = STAT_OK;
                     load_item.out_addr = rd_data_ff.addr;
                     load_item.out_chan = rd_data_ff.chan;
                     state_in           = S_IDLE;
                  end
               end
               FN_RESTORE: begin
                  if (out_free) begin
                     load                   = 1'b1;
                     load_last              = run_last;
                     load_item.status       = STAT_OK;
                     load_item.out_addr     = rd_data_ff.addr;
                     load_item.out_key_high = rd_data_ff.key_high;
                     load_item.out_key_low  = rd_data_ff.key_low;
                     load_item.out_chan     = rd_data_ff.chan;
                     if (run_last) begin
                        state_in = S_IDLE;
                     end else begin
                        run_in   = run_ff + 1'b1;
                        idx_in   = idx_ff + 1'b1;
                        state_in = S_RD;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_FIN: begin
            if (func_ff == FN_RESTORE || func_ff == FN_RSVD) begin
               // empty restore and the spare code give no result
               state_in = S_IDLE;
            end else if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               case (func_ff)
                  FN_SAVE: begin
                     if (free_vld_ff) begin
                        mem_we               = 1'b1;
                        mem_waddr            = free_idx_ff;
                        used_in[free_idx_ff] = 1'b1;
                        cnt_in               = cnt_ff + 1'b1;
                        load_item.status     = STAT_OK;
                     end else begin
                        load_item.status = STAT_NOSPACE;
                     end
                  end
                  FN_ERASE_ALL: begin
                     used_in          = '0;
                     cnt_in           = '0;
                     load_item.status = STAT_OK;
                  end
                  FN_COUNT: begin
                     load_item.status = STAT_OK;
                  end
                  default: begin
                     load_item.status = STAT_NOTFOUND;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      load_item.used_total = total_sat;
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         seen_ff     <= '0;
         run_ff      <= '0;
         free_vld_ff <= 1'b0;
         free_idx_ff <= '0;
         used_ff     <= '0;
         cnt_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         seen_ff     <= seen_in;
         run_ff      <= run_in;
         free_vld_ff <= free_vld_in;
         free_idx_ff <= free_idx_in;
         used_ff     <= used_in;
         cnt_ff      <= cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= func_type'(req_tuser);
         addr_ff <= req_tdata[ADDR_W-1:0];
         khi_ff  <= req_tdata[ADDR_W+KEY_W-1:ADDR_W];
         klo_ff  <= req_tdata[ADDR_W+2*KEY_W-1:ADDR_W+KEY_W];
         chan_ff <= req_tdata[ADDR_W+2*KEY_W+CHAN_W-1:ADDR_W+2*KEY_W];
         nth_ff  <= req_tdata[ADDR_W+2*KEY_W+CHAN_W+NTH_W-1:ADDR_W+2*KEY_W+CHAN_W];
      end
   end

   // slot memory; the walk only reads after earlier writes have landed
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem_ff[idx_ff];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= load_item;
         rsp_last_ff <= load_last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_ITEM_W)'(0), rsp_item_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ src/kpst_checker.sv @@
`include "keyed_peer_slot_table_top_macros.svh"

module kpst_checker #(
   parameter int SLOT_COUNT = 8
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [kpst_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [kpst_pkg::FUNC_W-1:0]      req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [kpst_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast
);
   import kpst_pkg::*;

   rsp_item_type item;
   logic         req_seen;

   assign item     = rsp_tdata[RSP_ITEM_W-1:0];
   assign req_seen = req_tvalid || (|req_tdata) || (|req_tuser);

   // a stalled result holds
   `KPST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // failures close the run and carry no entry
   `KPST_ASSERT_SAME(a_fail_clean, clock, reset, rsp_tvalid && item.status != STAT_OK,
      rsp_tlast && item.out_addr == '0 && item.out_key_high == '0 &&
      item.out_key_low == '0 && item.out_chan == '0)

   // count never beyond the table size
   `KPST_ASSERT_SAME(a_total_range, clock, reset, rsp_tvalid,
      int'(item.used_total) <= SLOT_COUNT)

   // mid restore run no new item is taken
   `KPST_ASSERT_SAME(a_run_busy, clock, reset, rsp_tvalid && !rsp_tlast,
      !req_tready || !req_seen && !req_tready)

endmodule

bind keyed_peer_slot_table_top kpst_checker #(
   .SLOT_COUNT (SLOT_COUNT)
) u_kpst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
